// ===== rtl/core/llac_pkg.sv =====
// ----------------------------------------------------------------------------
// llac_pkg: shared types and constants of the link-local address claimer
// Command and phase codes, register indexes, word layouts and fixed limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llac_pkg;

	localparam int unsigned PROBE_COUNT    = 3;
	localparam int unsigned ANNOUNCE_COUNT = 2;
	localparam int unsigned CONFLICT_LIMIT = 10;

	localparam logic [31:0] LL_FIRST = 32'hA9FE_0100;
	localparam logic [31:0] LL_LAST  = 32'hA9FE_FEFF;
	localparam logic [15:0] LL_SPAN  = 16'(LL_LAST + 32'd1 - LL_FIRST);

	localparam logic [2:0] PROBE_CNT_C    = 3'(PROBE_COUNT);
	localparam logic [2:0] ANNOUNCE_CNT_C = 3'(ANNOUNCE_COUNT);
	localparam logic [7:0] CONFLICT_LIM_C = 8'(CONFLICT_LIMIT);

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_ARP   = 2'd3;

	localparam logic [1:0] PH_OFF      = 2'd0;
	localparam logic [1:0] PH_PROBE    = 2'd1;
	localparam logic [1:0] PH_ANNOUNCE = 2'd2;
	localparam logic [1:0] PH_BOUND    = 2'd3;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_WAIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE_WAIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE_INTVL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEFEND         = 3'd7;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] address_random;
		logic [31:0] wait_random;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [47:0] sender_mac;
	} in_word_t;

	typedef struct packed {
		logic        send_probe;
		logic        send_announce;
		logic        bind_now;
		logic        link_down;
		logic        conflict_seen;
		logic [1:0]  phase;
		logic [31:0] claimed_address;
	} out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/link_local_address_claimer.sv =====
// ----------------------------------------------------------------------------
// link_local_address_claimer: IPv4 link-local address claim sequencer
// Takes start, stop, tick and ARP words; gives one result word per command.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one command word; out_valid/out_ready carry the
//   matching result word. cfg_we/cfg_index/cfg_data write a register at once.
//   A command is decoded in its accept cycle. A start or a restart folds the
//   address into the 65024 span in four steps (three shift-and-add folds, one
//   compare and subtract), then, for a random first wait, runs a 32-step
//   remainder on the shared restoring remainder unit; a probe tick runs one
//   for a random spacing. A result passes through the fold (claims only),
//   the remainder (random waits only) and the finish state into the result
//   register. One word at a time in the sequencer; in_ready is high only
//   while it is idle. The result register holds a finished word while
//   out_ready is low; the next command may be accepted then, and its result
//   waits in the sequencer until the register is free.
//   Reset clears the claim state to off, address 0, and loads the default
//   register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module link_local_address_claimer
	import llac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire in_word_t              in_word,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      out_word_t             out_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADDR = 2'd1;
	localparam logic [1:0] ST_WMOD = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [47:0] own_mac_q;
	logic [15:0] probe_wait_q, probe_min_q, probe_max_q;
	logic [15:0] ann_wait_q, ann_intvl_q, rate_limit_q, defend_q;

	logic [1:0]  phase_q;
	logic [15:0] wait_q;
	logic [2:0]  sent_q;
	logic [31:0] cand_q;
	logic [15:0] hold_q;
	logic [7:0]  try_q;

	logic [1:0]  state_q;
	logic [4:0]  bit_q;
	logic [31:0] dvd_q;
	logic [31:0] wrnd_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [15:0] add_q;
	logic        wpend_q;
	logic [4:0]  flags_q;

	logic        accept;
	logic [1:0]  n_phase;
	logic [15:0] n_wait;
	logic [2:0]  n_sent;
	logic [15:0] n_hold;
	logic [7:0]  n_try;
	logic        n_claim, n_wmod;
	logic [15:0] n_div, n_add;
	logic        f_probe, f_ann, f_bind, f_down, f_conf;
	logic        foreign, early;

	logic [15:0] divisor;
	logic [16:0] trial;
	logic [15:0] rem_next;
	logic        job_end;
	logic [31:0] fold_sum;
	logic [15:0] span_rem;
	logic        fold_end;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		n_phase = phase_q;
		n_wait  = wait_q;
		n_sent  = sent_q;
		n_hold  = hold_q;
		n_try   = try_q;
		n_claim = 1'b0;
		n_wmod  = 1'b0;
		n_div   = probe_wait_q;
		n_add   = 16'd0;
		f_probe = 1'b0;
		f_ann   = 1'b0;
		f_bind  = 1'b0;
		f_down  = 1'b0;
		f_conf  = 1'b0;
		foreign = (in_word.sender_mac != own_mac_q);
		early   = (phase_q == PH_PROBE) || (phase_q == PH_ANNOUNCE && sent_q == 3'd0);
		case (in_word.command)
			CMD_START: begin
				f_down  = 1'b1;
				n_claim = 1'b1;
			end
			CMD_STOP: begin
				n_phase = PH_OFF;
				f_down  = 1'b1;
			end
			CMD_TICK: begin
				if (hold_q != 16'd0)
					n_hold = hold_q - 16'd1;
				if (phase_q == PH_PROBE) begin
					if (wait_q != 16'd0) begin
						n_wait = wait_q - 16'd1;
					end else if (sent_q == PROBE_CNT_C) begin
						n_phase = PH_ANNOUNCE;
						n_sent  = 3'd0;
						n_wait  = ann_wait_q;
					end else begin
						f_probe = 1'b1;
						n_sent  = sent_q + 3'd1;
						if (probe_max_q > probe_min_q) begin
							n_wmod = 1'b1;
							n_div  = probe_max_q - probe_min_q;
							n_add  = probe_min_q;
						end else begin
							n_wait = probe_min_q;
						end
					end
				end else if (phase_q == PH_ANNOUNCE) begin
					if (wait_q != 16'd0) begin
						n_wait = wait_q - 16'd1;
					end else begin
						f_bind = (sent_q == 3'd0);
						if (sent_q == ANNOUNCE_CNT_C) begin
							n_phase = PH_BOUND;
							n_sent  = 3'd0;
							n_wait  = 16'd0;
						end else begin
							f_ann  = 1'b1;
							n_sent = sent_q + 3'd1;
							n_wait = ann_intvl_q;
						end
					end
				end
			end
			CMD_ARP: begin
				if (phase_q != PH_OFF) begin
					if (early) begin
						if (in_word.sender_ip == cand_q ||
						    (in_word.target_ip == cand_q && foreign)) begin
							f_conf  = 1'b1;
							f_down  = 1'b1;
							n_claim = 1'b1;
						end
					end else if (in_word.sender_ip == cand_q && foreign) begin
						f_conf = 1'b1;
						if (hold_q != 16'd0) begin
							f_down  = 1'b1;
							n_claim = 1'b1;
						end else begin
							f_ann  = 1'b1;
							n_hold = defend_q;
						end
					end
				end
			end
			default: ;
		endcase
		if (n_claim) begin
			n_hold  = 16'd0;
			n_phase = PH_PROBE;
			n_sent  = 3'd0;
			n_try   = (try_q != 8'hFF) ? try_q + 8'd1 : try_q;
			n_div   = probe_wait_q;
			n_add   = 16'd0;
			n_wmod  = 1'b0;
			if (n_try > CONFLICT_LIM_C)
				n_wait = rate_limit_q;
			else if (probe_wait_q != 16'd0)
				n_wmod = 1'b1;
			else
				n_wait = 16'd0;
		end
	end

	// shared restoring remainder step
	assign divisor  = div_q;
	assign trial    = {rem_q, dvd_q[31]};
	assign rem_next = (trial >= {1'b0, divisor}) ? 16'(trial - {1'b0, divisor}) : trial[15:0];
	assign job_end  = (bit_q == 5'd31);

	// fold the address word into the span: 2^16 leaves 512 over
	assign fold_sum = {7'd0, dvd_q[31:16], 9'd0} + {16'd0, dvd_q[15:0]};
	assign span_rem = (dvd_q[16:0] >= {1'b0, LL_SPAN}) ? 16'(dvd_q[16:0] - {1'b0, LL_SPAN})
		: dvd_q[15:0];
	assign fold_end = (bit_q == 5'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q    <= '0;
			probe_wait_q <= 16'd10;
			probe_min_q  <= 16'd10;
			probe_max_q  <= 16'd20;
			ann_wait_q   <= 16'd20;
			ann_intvl_q  <= 16'd20;
			rate_limit_q <= 16'd600;
			defend_q     <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_MAC:        own_mac_q    <= cfg_data;
				REG_PROBE_WAIT:     probe_wait_q <= cfg_data[15:0];
				REG_PROBE_MIN:      probe_min_q  <= cfg_data[15:0];
				REG_PROBE_MAX:      probe_max_q  <= cfg_data[15:0];
				REG_ANNOUNCE_WAIT:  ann_wait_q   <= cfg_data[15:0];
				REG_ANNOUNCE_INTVL: ann_intvl_q  <= cfg_data[15:0];
				REG_RATE_LIMIT:     rate_limit_q <= cfg_data[15:0];
				REG_DEFEND:         defend_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OFF;
			wait_q    <= '0;
			sent_q    <= '0;
			cand_q    <= '0;
			hold_q    <= '0;
			try_q     <= '0;
			state_q   <= ST_IDLE;
			bit_q     <= '0;
			wpend_q   <= 1'b0;
			flags_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= n_phase;
						wait_q  <= n_wait;
						sent_q  <= n_sent;
						hold_q  <= n_hold;
						try_q   <= n_try;
						wpend_q <= n_wmod;
						flags_q <= {f_probe, f_ann, f_bind, f_down, f_conf};
						bit_q   <= '0;
						if (n_claim)
							state_q <= ST_ADDR;
						else if (n_wmod)
							state_q <= ST_WMOD;
						else
							state_q <= ST_FIN;
					end
				end
				ST_ADDR: begin
					if (fold_end) begin
						bit_q   <= '0;
						cand_q  <= LL_FIRST + {16'd0, span_rem};
						state_q <= wpend_q ? ST_WMOD : ST_FIN;
					end else begin
						bit_q <= bit_q + 5'd1;
					end
				end
				ST_WMOD: begin
					bit_q <= bit_q + 5'd1;
					if (job_end) begin
						wait_q  <= rem_next + add_q;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIN && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// remainder datapath and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dvd_q  <= n_claim ? in_word.address_random : in_word.wait_random;
					wrnd_q <= in_word.wait_random;
					rem_q  <= '0;
					div_q  <= n_div;
					add_q  <= n_add;
				end
			end
			ST_ADDR: begin
				if (fold_end) begin
					dvd_q <= wrnd_q;
					rem_q <= '0;
				end else begin
					dvd_q <= fold_sum;
				end
			end
			ST_WMOD: begin
				dvd_q <= {dvd_q[30:0], 1'b0};
				rem_q <= rem_next;
			end
			ST_FIN: begin
				if (!out_valid || out_ready) begin
					out_word.send_probe      <= flags_q[4];
					out_word.send_announce   <= flags_q[3];
					out_word.bind_now        <= flags_q[2];
					out_word.link_down       <= flags_q[1];
					out_word.conflict_seen   <= flags_q[0];
					out_word.phase           <= phase_q;
					out_word.claimed_address <= cand_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_start_probes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word.command == CMD_START) |=> (phase_q == PH_PROBE))
		else $error("start did not enter probing");

	a_try_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (try_q >= $past(try_q)))
		else $error("try count went down");

	a_bind_in_announce: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.bind_now) |-> (out_word.phase == PH_ANNOUNCE))
		else $error("bind outside announcing");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR || state_q == ST_WMOD) |=> !$past(accept))
		else $error("word taken while remainder unit busy");
`endif

endmodule

`default_nettype wire

// ===== tb/link_local_address_claimer_test.sv =====
// ----------------------------------------------------------------------------
// link_local_address_claimer_test: self-checking bench for the address claimer
// Drives start, stop, tick and ARP words through the valid/ready input, works
// out each result word with a cycle-free model of the claim sequence and
// compares every result field. The run starts with directed words, then runs
// random claim sequences under several register settings, with random idling
// on both sides, a long receiver hold-off and a full drain between settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_local_address_claimer_test;
	import llac_pkg::*;

	localparam logic [31:0] LL_COUNT    = LL_LAST - LL_FIRST + 32'd1;
	localparam logic [47:0] MAC_ONES    = '1;
	localparam int          QUIET_LIMIT = 4000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          SETTLE      = 70;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_word_t              in_word   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_word;

	link_local_address_claimer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies
	logic [47:0] own_mac_r    = '0;
	logic [15:0] probe_wait_r = 16'd10;
	logic [15:0] probe_min_r  = 16'd10;
	logic [15:0] probe_max_r  = 16'd20;
	logic [15:0] ann_wait_r   = 16'd20;
	logic [15:0] ann_intvl_r  = 16'd20;
	logic [15:0] rate_limit_r = 16'd600;
	logic [15:0] defend_r     = 16'd100;

	// claim state
	logic [1:0]  claim_phase  = PH_OFF;
	logic [15:0] gap_left     = '0;
	logic [2:0]  sent_n       = '0;
	logic [31:0] cand_addr    = '0;
	logic [15:0] holdoff_left = '0;
	logic [7:0]  tries        = '0;

	in_word_t  pending_cmds[$];
	out_word_t claim_results[$];
	out_word_t want;
	int        mismatches = 0;
	logic      calm       = 1'b0;
	int        hold_req   = 0;
	int        hold_seen  = 0;
	int        hold_left  = 0;
	int        quiet      = 0;
	logic [31:0] addr_pick = '0;

	function automatic logic [31:0] cand_of(logic [31:0] addr_rnd);
		return LL_FIRST + addr_rnd % LL_COUNT;
	endfunction

	function automatic void restart_claim(logic [31:0] addr_rnd, logic [31:0] gap_rnd);
		holdoff_left = '0;
		cand_addr = cand_of(addr_rnd);
		if (tries != 8'hFF)
			tries = tries + 8'd1;
		claim_phase = PH_PROBE;
		sent_n = '0;
		gap_left = (probe_wait_r != 16'd0) ? 16'(gap_rnd % 32'(probe_wait_r)) : 16'd0;
		if (tries > CONFLICT_LIM_C)
			gap_left = rate_limit_r;
	endfunction

	function automatic out_word_t claim_step(in_word_t w);
		out_word_t r;
		logic foreign;
		r = '0;
		foreign = w.sender_mac != own_mac_r;
		case (w.command)
			CMD_START: begin
				r.link_down = 1'b1;
				restart_claim(w.address_random, w.wait_random);
			end
			CMD_STOP: begin
				claim_phase = PH_OFF;
				r.link_down = 1'b1;
			end
			CMD_TICK: begin
				if (holdoff_left != 16'd0)
					holdoff_left = holdoff_left - 16'd1;
				if (claim_phase == PH_PROBE) begin
					if (gap_left != 16'd0) begin
						gap_left = gap_left - 16'd1;
					end else if (sent_n == PROBE_CNT_C) begin
						claim_phase = PH_ANNOUNCE;
						sent_n = '0;
						gap_left = ann_wait_r;
					end else begin
						r.send_probe = 1'b1;
						sent_n = sent_n + 3'd1;
						if (probe_max_r > probe_min_r)
							gap_left = 16'(w.wait_random % 32'(probe_max_r - probe_min_r))
								+ probe_min_r;
						else
							gap_left = probe_min_r;
					end
				end else if (claim_phase == PH_ANNOUNCE) begin
					if (gap_left != 16'd0) begin
						gap_left = gap_left - 16'd1;
					end else begin
						if (sent_n == 3'd0)
							r.bind_now = 1'b1;
						if (sent_n == ANNOUNCE_CNT_C) begin
							claim_phase = PH_BOUND;
							sent_n = '0;
							gap_left = '0;
						end else begin
							r.send_announce = 1'b1;
							sent_n = sent_n + 3'd1;
							gap_left = ann_intvl_r;
						end
					end
				end
			end
			CMD_ARP: begin
				if (claim_phase == PH_PROBE
						|| (claim_phase == PH_ANNOUNCE && sent_n == 3'd0)) begin
					if (w.sender_ip == cand_addr || (w.target_ip == cand_addr && foreign)) begin
						r.conflict_seen = 1'b1;
						r.link_down = 1'b1;
						restart_claim(w.address_random, w.wait_random);
					end
				end else if (claim_phase != PH_OFF && w.sender_ip == cand_addr && foreign) begin
					r.conflict_seen = 1'b1;
					if (holdoff_left != 16'd0) begin
						r.link_down = 1'b1;
						restart_claim(w.address_random, w.wait_random);
					end else begin
						r.send_announce = 1'b1;
						holdoff_left = defend_r;
					end
				end
			end
			default: ;
		endcase
		r.phase = claim_phase;
		r.claimed_address = cand_addr;
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			if (in_valid && in_ready)
				claim_results.push_back(claim_step(in_word));
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
					in_valid <= 1'b1;
					in_word <= pending_cmds.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %0h, got %0h", name, want_v, got_v);
		end
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (claim_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word with none outstanding: %p", out_word);
				end else begin
					want = claim_results.pop_front();
					check_field("send_probe", want.send_probe, out_word.send_probe);
					check_field("send_announce", want.send_announce, out_word.send_announce);
					check_field("bind_now", want.bind_now, out_word.bind_now);
					check_field("link_down", want.link_down, out_word.link_down);
					check_field("conflict_seen", want.conflict_seen, out_word.conflict_seen);
					check_field("phase", want.phase, out_word.phase);
					check_field("claimed_address", want.claimed_address,
						out_word.claimed_address);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 9;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_word(input logic [1:0] cmd, input logic [31:0] addr_rnd,
			input logic [31:0] gap_rnd, input logic [31:0] sip, input logic [31:0] tip,
			input logic [47:0] smac);
		in_word_t w;
		w.command = cmd;
		w.address_random = addr_rnd;
		w.wait_random = gap_rnd;
		w.sender_ip = sip;
		w.target_ip = tip;
		w.sender_mac = smac;
		pending_cmds.push_back(w);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || claim_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_all(input logic [47:0] mac, input logic [15:0] pw,
			input logic [15:0] pmin, input logic [15:0] pmax, input logic [15:0] aw,
			input logic [15:0] ai, input logic [15:0] rl, input logic [15:0] df);
		logic [CFG_DATA_W-1:0] vals[8];
		vals = '{mac, 48'(pw), 48'(pmin), 48'(pmax), 48'(aw), 48'(ai), 48'(rl), 48'(df)};
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
		end
		own_mac_r = mac;
		probe_wait_r = pw;
		probe_min_r = pmin;
		probe_max_r = pmax;
		ann_wait_r = aw;
		ann_intvl_r = ai;
		rate_limit_r = rl;
		defend_r = df;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic fill_random(input int count);
		in_word_t w;
		int claim_left;
		int roll;
		logic [31:0] guess;
		claim_left = 0;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			guess = cand_of(addr_pick);
			w.address_random = addr_pick;
			w.wait_random = $urandom;
			w.sender_ip = ($urandom_range(3) == 0) ? guess : $urandom;
			w.target_ip = ($urandom_range(3) == 0) ? guess : $urandom;
			w.sender_mac = ($urandom_range(2) == 0) ? own_mac_r
				: {16'($urandom), 32'($urandom)};
			if (claim_left == 0) begin
				if ($urandom_range(4) == 0)
					addr_pick = $urandom;
				w.address_random = addr_pick;
				w.command = CMD_START;
				claim_left = $urandom_range(10, 70);
			end else begin
				claim_left--;
				if (roll < 85) begin
					w.command = CMD_TICK;
				end else if (roll < 93) begin
					w.command = CMD_ARP;
				end else if (roll < 95) begin
					w.command = CMD_STOP;
				end else if (roll < 97) begin
					w.command = CMD_START;
				end else begin
					w.command = 2'($urandom_range(3));
					w.address_random = $urandom;
					w.sender_ip = $urandom;
					w.target_ip = $urandom;
				end
			end
			pending_cmds.push_back(w);
		end
	endtask

	initial begin
		logic [15:0] lo;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_word(CMD_ARP, '0, '0, '0, '0, MAC_ONES);
		push_word(CMD_TICK, '1, '1, '1, '1, MAC_ONES);
		push_word(CMD_STOP, '1, '1, '1, '1, MAC_ONES);
		push_word(CMD_START, '1, '1, '0, '0, '0);
		push_word(CMD_TICK, '0, '0, '0, '0, '0);
		push_word(CMD_ARP, '0, '0, '0, cand_of('1), '0);
		push_word(CMD_ARP, '0, '0, '0, cand_of('1), MAC_ONES);
		push_word(CMD_TICK, '0, '1, '0, '0, '0);
		push_word(CMD_ARP, 32'd65023, '0, LL_FIRST, '0, '0);
		push_word(CMD_TICK, '0, '0, '0, '0, '0);
		push_word(CMD_STOP, '0, '0, '0, '0, '0);
		push_word(CMD_ARP, '0, '0, cand_of(32'd65023), '0, MAC_ONES);
		push_word(CMD_START, 32'd65024, 32'd9, '0, '0, '0);
		push_word(CMD_TICK, '0, '0, '0, '0, '0);
		drain();

		write_all(MAC_ONES, '0, '0, '0, '0, '0, '0, '0);
		push_word(CMD_START, 32'd1, $urandom, '0, '0, '0);
		repeat (7) push_word(CMD_TICK, '0, $urandom, '0, '0, '0);
		push_word(CMD_ARP, '0, '0, cand_of(32'd1), '0, '0);
		push_word(CMD_ARP, '0, '0, cand_of(32'd1), '0, '0);
		push_word(CMD_TICK, '0, '0, '0, '0, '0);
		drain();

		for (int p = 0; p < 9; p++) begin
			lo = 16'($urandom_range(0, 4));
			case (p)
				0: write_all('0, '1, '1, '1, '1, '1, '1, '1);
				1: write_all({16'($urandom), 32'($urandom)}, 16'($urandom_range(1, 6)),
					16'd6, 16'd2, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
					16'($urandom_range(0, 8)), 16'($urandom_range(1, 40)));
				default: write_all({16'($urandom), 32'($urandom)},
					16'($urandom_range(1, 6)), lo, lo + 16'($urandom_range(1, 6)),
					16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
					16'($urandom_range(0, 8)), 16'($urandom_range(1, 40)));
			endcase
			calm = (p == 3);
			if (p == 4)
				hold_req++;
			if (p == 0) begin
				fill_random(40);
			end else if (p == 5) begin
				fill_random(120);
				drain();
				fill_random(120);
			end else begin
				fill_random(240);
			end
			drain();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/llac_pkg.sv
rtl/core/link_local_address_claimer.sv
tb/link_local_address_claimer_test.sv
